// ----- src/piawt_pkg.sv -----
// Package for the PI tracker with rate damper and anti-windup.
// Holds register indexes, fixed field widths, reset values and the sequencer state type.
// No dependencies.
`default_nettype none

package piawt_pkg;

	// fixed widths of the configuration fields
	localparam int GAIN_W     = 18;
	localparam int TIME_W     = 16;
	localparam int LIMIT_W    = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// product sum Q.26 to drive Q.12
	localparam int ROUND_SHIFT = 14;
	// asr applied to the integrator before its gain product
	localparam int INTEG_SHIFT = 16;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_PROP     = 3'd0,
		REG_GAIN_INTEGRAL = 3'd1,
		REG_GAIN_DAMPER   = 3'd2,
		REG_STEP_TIME     = 3'd3,
		REG_DRIVE_UPPER   = 3'd4,
		REG_DRIVE_LOWER   = 3'd5,
		REG_WINDUP_SENSE  = 3'd6
	} cfg_reg_t;

	// register reset values
	localparam logic signed [GAIN_W-1:0]  GAIN_PROP_RST     = 18'sd8192;
	localparam logic signed [GAIN_W-1:0]  GAIN_INTEGRAL_RST = 18'sd2458;
	localparam logic signed [GAIN_W-1:0]  GAIN_DAMPER_RST   = 18'sd164;
	localparam logic        [TIME_W-1:0]  STEP_TIME_RST     = 16'd1311;
	localparam logic signed [LIMIT_W-1:0] DRIVE_UPPER_RST   = 24'sd2048;
	localparam logic signed [LIMIT_W-1:0] DRIVE_LOWER_RST   = -24'sd2048;

	// sequencer states; each ST_MUL state drives one step of the shared multiplier
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ERR,
		ST_MUL_DT,
		ST_INTEG,
		ST_MUL_P,
		ST_MUL_I,
		ST_MUL_D,
		ST_SUM,
		ST_CLAMP
	} seq_state_t;

endpackage

`default_nettype wire

// ----- src/pi_damper_anti_windup_tracker.sv -----
// Top level of the single-axis PI tracker with rate damper and anti-windup.
// Depends on piawt_pkg (register indexes, widths, reset values, state type).
`default_nettype none
//
// Usage
//   Input channel (in_valid/in_ready): one transfer carries reference, measured,
//   body_rate and clear for one control step. in_ready is high only while the
//   sequencer is idle; it drops for the whole of one step.
//   Output channel (out_valid/out_ready): one transfer per input step, carrying
//   drive, at_limit and integrating. The result sits in an output register, so the
//   next input is taken while an earlier result still waits.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data): cfg_ready is
//   always high; write only while no step is in flight. Unknown indexes are dropped.
// Sequence
//   One step runs through eight sequencer states after its transfer. The next input
//   is taken only once the step has left the clamp state, which a stalled receiver
//   can hold. The sequence is shaped by the one shared 18 x N multiplier, used four
//   times per step (error times step time, then the proportional, integral and
//   damper products), each followed by an add or, for the damper, a subtract.
//   A clear step skips the arithmetic: it goes from the error to the clamp state.
// Reset
//   arst_n clears the integrator, sets the integration enable and loads the default
//   gains, step time and limits. If the receiver stalls, the finished step waits in
//   the clamp state until the output register is free; nothing is dropped.
//
module pi_damper_anti_windup_tracker
	import piawt_pkg::*;
#(
	parameter int SIGNAL_WIDTH   = 24,
	parameter int INTEGRAL_WIDTH = 40
) (
	input  wire                           clk,
	input  wire                           arst_n,
	// configuration writes
	input  wire                           cfg_valid,
	output logic                          cfg_ready,
	input  wire        [CFG_IDX_W-1:0]    cfg_index,
	input  wire        [CFG_DATA_W-1:0]   cfg_data,
	// input items
	input  wire                           in_valid,
	output logic                          in_ready,
	input  wire signed [SIGNAL_WIDTH-1:0] reference,
	input  wire signed [SIGNAL_WIDTH-1:0] measured,
	input  wire signed [SIGNAL_WIDTH-1:0] body_rate,
	input  wire                           clear,
	// result items
	output logic                          out_valid,
	input  wire                           out_ready,
	output logic signed [SIGNAL_WIDTH-1:0] drive,
	output logic                          at_limit,
	output logic                          integrating
);

	// multiplier B operand: wide enough for error, rate and the shifted integrator
	localparam int IQ_W  = INTEGRAL_WIDTH - INTEG_SHIFT;
	localparam int BW    = (SIGNAL_WIDTH > IQ_W) ? SIGNAL_WIDTH : IQ_W;
	localparam int PW    = GAIN_W + BW;
	// three products summed with two guard bits
	localparam int SUM_W = PW + 2;
	// integrator add width
	localparam int AW    = ((INTEGRAL_WIDTH > PW) ? INTEGRAL_WIDTH : PW) + 1;

	localparam logic signed [AW-1:0] I_MAX =
		{{(AW-INTEGRAL_WIDTH+1){1'b0}}, {(INTEGRAL_WIDTH-1){1'b1}}};
	localparam logic signed [AW-1:0] I_MIN = ~I_MAX;
	localparam logic signed [SUM_W-1:0] D_MAX =
		{{(SUM_W-SIGNAL_WIDTH+1){1'b0}}, {(SIGNAL_WIDTH-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] D_MIN = ~D_MAX;
	localparam logic signed [SUM_W-1:0] RND_BIAS = SUM_W'(1) <<< (ROUND_SHIFT - 1);

	// configuration registers
	logic signed [GAIN_W-1:0]  gain_prop_q;
	logic signed [GAIN_W-1:0]  gain_integral_q;
	logic signed [GAIN_W-1:0]  gain_damper_q;
	logic        [TIME_W-1:0]  step_time_q;
	logic signed [LIMIT_W-1:0] drive_upper_q;
	logic signed [LIMIT_W-1:0] drive_lower_q;
	logic                      windup_sense_q;

	// controller state
	logic signed [INTEGRAL_WIDTH-1:0] integ_q;
	logic                             enable_q;

	// step operands and working registers
	logic signed [SIGNAL_WIDTH-1:0] ref_q;
	logic signed [SIGNAL_WIDTH-1:0] meas_q;
	logic signed [SIGNAL_WIDTH-1:0] rate_q;
	logic                           clear_q;
	logic signed [SIGNAL_WIDTH-1:0] err_q;
	logic signed [PW-1:0]           prod_q;
	logic signed [SUM_W-1:0]        acc_q;

	// output register
	logic                           out_valid_q;
	logic signed [SIGNAL_WIDTH-1:0] drive_q;
	logic                           at_limit_q;
	logic                           integrating_q;

	seq_state_t state_q;
	seq_state_t state_d;

	// shared multiplier operands
	logic signed [GAIN_W-1:0] mul_a;
	logic signed [BW-1:0]     mul_b;

	logic in_xfer;
	logic out_free;

	// combinational datapath pieces
	logic signed [SIGNAL_WIDTH:0]   diff;
	logic signed [SIGNAL_WIDTH-1:0] err_sat;
	logic signed [AW-1:0]           integ_sum;
	logic signed [INTEGRAL_WIDTH-1:0] integ_sat;
	logic signed [SUM_W-1:0]        rnd_sum;
	logic signed [SUM_W-1:0]        drv_full;
	logic signed [SUM_W-1:0]        upper_ext;
	logic signed [SUM_W-1:0]        lower_ext;
	logic signed [SUM_W-1:0]        clamp_v;
	logic signed [SIGNAL_WIDTH-1:0] drive_sat;
	logic                           hit_upper;
	logic                           hit_lower;
	logic                           push;
	logic                           next_enable;

	assign cfg_ready   = 1'b1;
	assign in_xfer     = in_valid && in_ready;
	assign out_free    = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign drive       = drive_q;
	assign at_limit    = at_limit_q;
	assign integrating = integrating_q;

	// ---------------------------------------------------------------
	// Configuration writes
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_prop_q     <= GAIN_PROP_RST;
			gain_integral_q <= GAIN_INTEGRAL_RST;
			gain_damper_q   <= GAIN_DAMPER_RST;
			step_time_q     <= STEP_TIME_RST;
			drive_upper_q   <= DRIVE_UPPER_RST;
			drive_lower_q   <= DRIVE_LOWER_RST;
			windup_sense_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_GAIN_PROP:     gain_prop_q     <= cfg_data[GAIN_W-1:0];
				REG_GAIN_INTEGRAL: gain_integral_q <= cfg_data[GAIN_W-1:0];
				REG_GAIN_DAMPER:   gain_damper_q   <= cfg_data[GAIN_W-1:0];
				REG_STEP_TIME:     step_time_q     <= cfg_data[TIME_W-1:0];
				REG_DRIVE_UPPER:   drive_upper_q   <= cfg_data[LIMIT_W-1:0];
				REG_DRIVE_LOWER:   drive_lower_q   <= cfg_data[LIMIT_W-1:0];
				REG_WINDUP_SENSE:  windup_sense_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Sequencer: next state
	// ---------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_xfer) state_d = ST_ERR;
			// a clear step goes straight to the output stage
			ST_ERR:    state_d = clear_q ? ST_CLAMP : ST_MUL_DT;
			ST_MUL_DT: state_d = ST_INTEG;
			ST_INTEG:  state_d = ST_MUL_P;
			ST_MUL_P:  state_d = ST_MUL_I;
			ST_MUL_I:  state_d = ST_MUL_D;
			ST_MUL_D:  state_d = ST_SUM;
			ST_SUM:    state_d = ST_CLAMP;
			// hold until the output register is free
			ST_CLAMP:  if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// ---------------------------------------------------------------
	// Sequencer: outputs (handshake and multiplier operand select)
	// ---------------------------------------------------------------
	always_comb begin
		in_ready = 1'b0;
		mul_a    = gain_prop_q;
		mul_b    = BW'(err_q);
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_MUL_DT: begin
				// step time is unsigned: zero extend into the signed operand
				mul_a = $signed({{(GAIN_W-TIME_W){1'b0}}, step_time_q});
				mul_b = BW'(err_q);
			end
			ST_MUL_P: begin
				mul_a = gain_prop_q;
				mul_b = BW'(err_q);
			end
			ST_MUL_I: begin
				mul_a = gain_integral_q;
				mul_b = BW'($signed(integ_q[INTEGRAL_WIDTH-1:INTEG_SHIFT]));
			end
			ST_MUL_D: begin
				mul_a = gain_damper_q;
				mul_b = BW'(rate_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ---------------------------------------------------------------
	// Datapath arithmetic
	// ---------------------------------------------------------------
	always_comb begin
		// error, saturated to the signal width
		diff = {ref_q[SIGNAL_WIDTH-1], ref_q} - {meas_q[SIGNAL_WIDTH-1], meas_q};
		if (diff[SIGNAL_WIDTH] != diff[SIGNAL_WIDTH-1]) begin
			err_sat = {diff[SIGNAL_WIDTH], {(SIGNAL_WIDTH-1){~diff[SIGNAL_WIDTH]}}};
		end else begin
			err_sat = diff[SIGNAL_WIDTH-1:0];
		end

		// integrator plus error times step time, saturated
		integ_sum = AW'(integ_q) + AW'(prod_q);
		if (integ_sum > I_MAX) begin
			integ_sat = I_MAX[INTEGRAL_WIDTH-1:0];
		end else if (integ_sum < I_MIN) begin
			integ_sat = I_MIN[INTEGRAL_WIDTH-1:0];
		end else begin
			integ_sat = integ_sum[INTEGRAL_WIDTH-1:0];
		end

		// round half up from Q.26 to Q.12
		rnd_sum  = acc_q + RND_BIAS;
		drv_full = rnd_sum >>> ROUND_SHIFT;

		// clamp: upper test first and wins
		upper_ext = SUM_W'(drive_upper_q);
		lower_ext = SUM_W'(drive_lower_q);
		hit_upper = (drv_full >= upper_ext);
		hit_lower = !hit_upper && (drv_full <= lower_ext);
		if (hit_upper) begin
			clamp_v = upper_ext;
		end else if (hit_lower) begin
			clamp_v = lower_ext;
		end else begin
			clamp_v = drv_full;
		end

		// limits may lie outside the signal range
		if (clamp_v > D_MAX) begin
			drive_sat = D_MAX[SIGNAL_WIDTH-1:0];
		end else if (clamp_v < D_MIN) begin
			drive_sat = D_MIN[SIGNAL_WIDTH-1:0];
		end else begin
			drive_sat = clamp_v[SIGNAL_WIDTH-1:0];
		end

		// stop integrating when the error drives further into the active limit;
		// a zero error never counts as pushing
		push = 1'b0;
		if (hit_upper) begin
			push = windup_sense_q ? err_q[SIGNAL_WIDTH-1]
			                      : (!err_q[SIGNAL_WIDTH-1] && (err_q != '0));
		end else if (hit_lower) begin
			push = windup_sense_q ? (!err_q[SIGNAL_WIDTH-1] && (err_q != '0))
			                      : err_q[SIGNAL_WIDTH-1];
		end
		next_enable = clear_q || !push;
	end

	// ---------------------------------------------------------------
	// Step operands and working registers (payload, no reset)
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		// shared multiplier, registered every cycle
		prod_q <= mul_a * mul_b;

		if (in_xfer) begin
			ref_q   <= reference;
			meas_q  <= measured;
			rate_q  <= body_rate;
			clear_q <= clear;
		end

		case (state_q)
			ST_ERR:   err_q <= err_sat;
			// proportional product lands here; start the sum
			ST_MUL_I: acc_q <= SUM_W'(prod_q);
			// add the integral term
			ST_MUL_D: acc_q <= acc_q + SUM_W'(prod_q);
			// subtract the damper term
			ST_SUM:   acc_q <= acc_q - SUM_W'(prod_q);
			default: ;
		endcase

		if (state_q == ST_CLAMP && out_free) begin
			if (clear_q) begin
				drive_q       <= '0;
				at_limit_q    <= 1'b0;
				integrating_q <= 1'b1;
			end else begin
				drive_q       <= drive_sat;
				at_limit_q    <= hit_upper || hit_lower;
				integrating_q <= next_enable;
			end
		end
	end

	// ---------------------------------------------------------------
	// Controller state and output valid
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q     <= '0;
			enable_q    <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_ERR && clear_q) begin
				integ_q <= '0;
			end else if (state_q == ST_INTEG && enable_q) begin
				integ_q <= integ_sat;
			end

			if (state_q == ST_CLAMP && out_free) begin
				enable_q    <= next_enable;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				// drop the valid once the result transfers
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ----- bench/piawt_drive_checker.sv -----
// Checker for the PI tracker: watches the configuration, input and result channels,
// predicts each drive result and compares it with what the block hands out.
// Depends on piawt_pkg (register indexes, field widths, register reset values).
`default_nettype none

module piawt_drive_checker
	import piawt_pkg::*;
#(
	parameter int SIG_W = 24,
	parameter int INT_W = 40
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     cfg_valid,
	input  wire                     cfg_ready,
	input  wire [CFG_IDX_W-1:0]     cfg_index,
	input  wire [CFG_DATA_W-1:0]    cfg_data,
	input  wire                     in_valid,
	input  wire                     in_ready,
	input  wire signed [SIG_W-1:0]  reference,
	input  wire signed [SIG_W-1:0]  measured,
	input  wire signed [SIG_W-1:0]  body_rate,
	input  wire                     clear,
	input  wire                     out_valid,
	input  wire                     out_ready,
	input  wire signed [SIG_W-1:0]  drive,
	input  wire                     at_limit,
	input  wire                     integrating,
	output int                      mismatch_count,
	output int                      results_checked,
	output int                      limit_hits,
	output int                      held_steps
);

	localparam int MAX_REPORTS = 10;

	typedef struct {
		logic signed [SIG_W-1:0] drive;
		logic                    at_limit;
		logic                    integrating;
	} drive_result_t;

	// shadow of the configuration registers
	longint gain_p, gain_i, gain_d, step_dt, limit_hi, limit_lo;
	bit     wind_sense;
	// shadow of the loop state
	longint integ_acc;
	bit     integ_on;

	drive_result_t expected_drives[$];
	drive_result_t want;

	function automatic longint clip(input longint x, input int w);
		longint hi;
		hi = (longint'(1) <<< (w - 1)) - 1;
		if (x > hi) return hi;
		if (x < -hi - 1) return -hi - 1;
		return x;
	endfunction

	// one control step: clear the loop, or integrate, mix the three terms, clamp, decide on windup
	function automatic drive_result_t advance_loop(
		input logic signed [SIG_W-1:0] setpoint,
		input logic signed [SIG_W-1:0] sensed,
		input logic signed [SIG_W-1:0] rate_in,
		input logic                    clr
	);
		drive_result_t res;
		longint err, rate, mix, level;
		bit hit_hi, hit_lo, pushing;
		res.drive = '0;
		res.at_limit = 1'b0;
		res.integrating = 1'b1;
		if (clr) begin
			integ_acc = 0;
			integ_on = 1'b1;
		end else begin
			err = clip(longint'(setpoint) - longint'(sensed), SIG_W);
			rate = rate_in;
			if (integ_on)
				integ_acc = clip(integ_acc + err * step_dt, INT_W);
			mix = gain_p * err + gain_i * (integ_acc >>> INTEG_SHIFT) - gain_d * rate;
			level = (mix + (longint'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
			// upper test first: it wins when the limits cross
			hit_hi = (level >= limit_hi);
			hit_lo = !hit_hi && (level <= limit_lo);
			pushing = 1'b0;
			if (hit_hi) begin
				level = limit_hi;
				pushing = wind_sense ? (err < 0) : (err > 0);
			end else if (hit_lo) begin
				level = limit_lo;
				pushing = wind_sense ? (err > 0) : (err < 0);
			end
			integ_on = !pushing;
			res.drive = SIG_W'(clip(level, SIG_W));
			res.at_limit = hit_hi || hit_lo;
			res.integrating = integ_on;
		end
		return res;
	endfunction

	task automatic log_miss(input string what, input drive_result_t exp_r);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("[%0t] %s: exp drive %0d lim %0b int %0b, got drive %0d lim %0b int %0b",
				$time, what, exp_r.drive, exp_r.at_limit, exp_r.integrating,
				drive, at_limit, integrating);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p = GAIN_PROP_RST;
			gain_i = GAIN_INTEGRAL_RST;
			gain_d = GAIN_DAMPER_RST;
			step_dt = STEP_TIME_RST;
			limit_hi = DRIVE_UPPER_RST;
			limit_lo = DRIVE_LOWER_RST;
			wind_sense = 1'b0;
			integ_acc = 0;
			integ_on = 1'b1;
			expected_drives.delete();
			mismatch_count = 0;
			results_checked = 0;
			limit_hits = 0;
			held_steps = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_drives.size() == 0) begin
					want = '{default: '0};
					log_miss("result with no step pending", want);
				end else begin
					want = expected_drives.pop_front();
					if (drive !== want.drive || at_limit !== want.at_limit ||
					    integrating !== want.integrating)
						log_miss("result mismatch", want);
				end
				results_checked++;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_GAIN_PROP:     gain_p = $signed(cfg_data[GAIN_W-1:0]);
					REG_GAIN_INTEGRAL: gain_i = $signed(cfg_data[GAIN_W-1:0]);
					REG_GAIN_DAMPER:   gain_d = $signed(cfg_data[GAIN_W-1:0]);
					REG_STEP_TIME:     step_dt = cfg_data[TIME_W-1:0];
					REG_DRIVE_UPPER:   limit_hi = $signed(cfg_data[LIMIT_W-1:0]);
					REG_DRIVE_LOWER:   limit_lo = $signed(cfg_data[LIMIT_W-1:0]);
					REG_WINDUP_SENSE:  wind_sense = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				want = advance_loop(reference, measured, body_rate, clear);
				if (want.at_limit) limit_hits++;
				if (!want.integrating) held_steps++;
				expected_drives.push_back(want);
			end
		end
	end

endmodule

`default_nettype wire

// ----- bench/pi_damper_anti_windup_tracker_tb.sv -----
// Testbench top for the PI tracker: clock, reset, stimulus on the configuration and
// input channels, a stalling receiver, and the verdict.
// Depends on piawt_pkg, pi_damper_anti_windup_tracker and piawt_drive_checker.
`default_nettype none

module pi_damper_anti_windup_tracker_tb;
	import piawt_pkg::*;

	localparam int SIG_W           = 24;
	localparam int CYCLE_LIMIT     = 400000;
	localparam int RANDOM_PHASES   = 9;
	localparam int ITEMS_PER_PHASE = 150;
	// long receiver hold-off, started once mid-phase
	localparam int HOLDOFF_AT      = 420;
	localparam int HOLDOFF_CYCLES  = 700;
	localparam int DRAIN_CYCLES    = 30;

	// index with no register behind it; the block must drop the write
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

	localparam logic signed [SIG_W-1:0]  SIG_MAX  = {1'b0, {(SIG_W-1){1'b1}}};
	localparam logic signed [SIG_W-1:0]  SIG_MIN  = {1'b1, {(SIG_W-1){1'b0}}};
	localparam logic signed [GAIN_W-1:0] GAIN_MAX = {1'b0, {(GAIN_W-1){1'b1}}};
	localparam logic signed [GAIN_W-1:0] GAIN_MIN = {1'b1, {(GAIN_W-1){1'b0}}};
	localparam logic [TIME_W-1:0]        TIME_MAX = '1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_data = '0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic signed [SIG_W-1:0] reference = '0;
	logic signed [SIG_W-1:0] measured = '0;
	logic signed [SIG_W-1:0] body_rate = '0;
	logic                    clear = 1'b0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic signed [SIG_W-1:0] drive;
	logic                    at_limit;
	logic                    integrating;

	int mismatch_count, results_checked, limit_hits, held_steps;
	int items_sent = 0;
	int settings_count = 0;
	int burst_left = 0;
	int cycle_count = 0;

	pi_damper_anti_windup_tracker u_dut (.*);
	piawt_drive_checker u_checker (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// watchdog: a correct run ends far below this
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", CYCLE_LIMIT);
			$display("Mismatches found");
			$finish;
		end
	end

	// Random value in [-span, span]
	function automatic int spread(input int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	// Pick a signal-range corner: both extremes, zero, plus or minus one
	function automatic logic signed [SIG_W-1:0] signal_edge();
		case ($urandom_range(0, 4))
			0: return SIG_MAX;
			1: return SIG_MIN;
			2: return '0;
			3: return SIG_W'(1);
			default: return SIG_W'(-1);
		endcase
	endfunction

	// Gain word: the unused upper bits of the data carry junk on purpose
	function automatic logic [CFG_DATA_W-1:0] pick_gain();
		logic [CFG_DATA_W-1:0] word;
		word = CFG_DATA_W'($urandom);
		case ($urandom_range(0, 5))
			0: word[GAIN_W-1:0] = GAIN_MAX;
			1: word[GAIN_W-1:0] = GAIN_MIN;
			2: word[GAIN_W-1:0] = '0;
			3: ;
			default: word[GAIN_W-1:0] = GAIN_W'(spread(1 << 15));
		endcase
		return word;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_time();
		logic [CFG_DATA_W-1:0] word;
		word = CFG_DATA_W'($urandom);
		case ($urandom_range(0, 4))
			0: word[TIME_W-1:0] = TIME_MAX;
			1: word[TIME_W-1:0] = '0;
			2: ;
			default: word[TIME_W-1:0] = TIME_W'($urandom_range(200, 4000));
		endcase
		return word;
	endfunction

	// Limits mostly sit on their own side of zero; the other picks let them cross
	function automatic logic [CFG_DATA_W-1:0] pick_limit(input bit upper_side);
		int mag;
		mag = $urandom_range(0, 1 << 14);
		case ($urandom_range(0, 6))
			0: return signal_edge();
			1: return CFG_DATA_W'($urandom);
			2: return CFG_DATA_W'(spread(1 << 12));
			default: return upper_side ? CFG_DATA_W'(mag) : CFG_DATA_W'(-mag);
		endcase
	endfunction

	// Write one register; leave cfg_valid up so back-to-back writes need one assignment
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] word);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= word;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic end_writes();
		cfg_valid <= 1'b0;
		settings_count++;
	endtask

	// Hold until every accepted step has handed back its result
	task automatic await_idle();
		wait (results_checked == items_sent);
	endtask

	// Offer one step and hold it until the transfer; insert a gap at the end of a burst
	task automatic send_step(
		input logic signed [SIG_W-1:0] setpoint,
		input logic signed [SIG_W-1:0] sensed,
		input logic signed [SIG_W-1:0] rate,
		input logic                    clr
	);
		in_valid <= 1'b1;
		reference <= setpoint;
		measured <= sensed;
		body_rate <= rate;
		clear <= clr;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			// now and then a long stretch with no gaps at all
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 200)
			                                          : $urandom_range(1, 24);
		end
	endtask

	// Drop valid after the last step of a phase, unless a gap already did
	task automatic stop_offer();
		if (in_valid) in_valid <= 1'b0;
	endtask

	task automatic random_step();
		logic signed [SIG_W-1:0] setpoint, sensed, rate;
		logic clr;
		int pick;
		pick = $urandom_range(0, 99);
		clr = ($urandom_range(0, 39) == 0);
		if (pick < 60) begin
			// typical tracking: small error and rate around the clamp scale
			setpoint = SIG_W'(spread(1 << 15));
			sensed = setpoint + SIG_W'(spread(1 << 12));
			rate = SIG_W'(spread(1 << 12));
		end else if (pick < 85) begin
			setpoint = SIG_W'($urandom);
			sensed = SIG_W'($urandom);
			rate = SIG_W'($urandom);
		end else begin
			setpoint = signal_edge();
			sensed = signal_edge();
			rate = signal_edge();
		end
		send_step(setpoint, sensed, rate, clr);
	endtask

	task automatic random_settings();
		write_reg(REG_GAIN_PROP, pick_gain());
		write_reg(REG_GAIN_INTEGRAL, pick_gain());
		write_reg(REG_GAIN_DAMPER, pick_gain());
		write_reg(REG_STEP_TIME, pick_time());
		write_reg(REG_DRIVE_UPPER, pick_limit(1'b1));
		write_reg(REG_DRIVE_LOWER, pick_limit(1'b0));
		write_reg(REG_WINDUP_SENSE, CFG_DATA_W'($urandom));
		if ($urandom_range(0, 2) == 0)
			write_reg(REG_SPARE, CFG_DATA_W'($urandom));
		end_writes();
	endtask

	// Receiver: stall on a rotating 16-bit pattern, re-picked every so often, with
	// stretches of no stalls; once, hold off long enough to back up the input side
	initial begin : receiver
		logic [15:0] stall_pattern;
		int          pat_pos;
		int          pat_left;
		bit          holdoff_done;
		stall_pattern = '0;
		pat_pos = 0;
		pat_left = 0;
		holdoff_done = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (!holdoff_done && items_sent >= HOLDOFF_AT) begin
				holdoff_done = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLDOFF_CYCLES) @(posedge clk);
			end
			if (pat_left == 0) begin
				pat_left = $urandom_range(20, 200);
				case ($urandom_range(0, 3))
					0: stall_pattern = '0;
					1: stall_pattern = 16'($urandom);
					2: stall_pattern = 16'($urandom) & 16'($urandom);
					default: stall_pattern = 16'($urandom) | 16'($urandom);
				endcase
			end
			pat_left--;
			pat_pos = (pat_pos + 1) % 16;
			out_ready <= !stall_pattern[pat_pos];
		end
	end

	initial begin : stimulus
		burst_left = $urandom_range(1, 24);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Default registers: clear with extreme fields, saturated errors both ways,
		// integration held on the next step, zero error sitting on each limit.
		send_step(SIG_MAX, SIG_MIN, SIG_MIN, 1'b1);
		send_step('0, '0, '0, 1'b0);
		send_step(SIG_MAX, SIG_MIN, '0, 1'b0);
		send_step(SIG_MAX, SIG_MIN, '0, 1'b0);
		send_step(SIG_W'(100), SIG_W'(100), SIG_MIN, 1'b0);
		send_step(SIG_MIN, SIG_MAX, '0, 1'b0);
		send_step(SIG_W'(-5), SIG_W'(-5), SIG_MAX, 1'b0);
		send_step(SIG_W'(1000), SIG_W'(900), SIG_W'(-50), 1'b0);
		send_step('0, '0, '0, 1'b1);
		send_step(SIG_W'(-1), SIG_W'(1), SIG_MAX, 1'b0);
		stop_offer();
		await_idle();

		// Extreme gains and step time, widest limits, reversed sense: the integrator
		// runs into saturation and the drive into the signal range ends.
		write_reg(REG_GAIN_PROP, CFG_DATA_W'(GAIN_MIN));
		write_reg(REG_GAIN_INTEGRAL, CFG_DATA_W'(GAIN_MAX));
		write_reg(REG_GAIN_DAMPER, CFG_DATA_W'(GAIN_MIN));
		write_reg(REG_STEP_TIME, CFG_DATA_W'(TIME_MAX));
		write_reg(REG_DRIVE_UPPER, SIG_MAX);
		write_reg(REG_DRIVE_LOWER, SIG_MIN);
		write_reg(REG_WINDUP_SENSE, CFG_DATA_W'(1));
		write_reg(REG_SPARE, '1);
		end_writes();
		repeat (3) send_step(SIG_MAX, SIG_MIN, '0, 1'b0);
		repeat (2) send_step(SIG_MIN, SIG_MAX, SIG_MAX, 1'b0);
		send_step('0, '0, '0, 1'b1);
		stop_offer();
		await_idle();

		// Crossed limits with zero integral path: the upper test must win
		write_reg(REG_GAIN_INTEGRAL, '0);
		write_reg(REG_GAIN_DAMPER, '0);
		write_reg(REG_GAIN_PROP, CFG_DATA_W'(GAIN_PROP_RST));
		write_reg(REG_STEP_TIME, '0);
		write_reg(REG_DRIVE_UPPER, CFG_DATA_W'(-100));
		write_reg(REG_DRIVE_LOWER, CFG_DATA_W'(100));
		write_reg(REG_WINDUP_SENSE, CFG_DATA_W'(0));
		end_writes();
		send_step('0, '0, '0, 1'b0);
		send_step(SIG_W'(50), '0, '0, 1'b0);
		send_step(SIG_W'(-5000), '0, '0, 1'b0);
		stop_offer();
		await_idle();

		// Random phases, each under a fresh register setting
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			random_settings();
			repeat (ITEMS_PER_PHASE) random_step();
			stop_offer();
			await_idle();
		end

		// let any stray result surface before the verdict
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d steps under %0d register settings, %0d results checked.",
			items_sent, settings_count, results_checked);
		$display("%0d steps clamped, %0d left integration held; one %0d-cycle receiver hold-off.",
			limit_hits, held_steps, HOLDOFF_CYCLES);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire

// ----- files.f -----
src/piawt_pkg.sv
src/pi_damper_anti_windup_tracker.sv
bench/piawt_drive_checker.sv
bench/pi_damper_anti_windup_tracker_tb.sv
